>>> rtl/wtm_pkg.sv
// Shared constants and types for the windowed throughput meter.
`default_nettype none
package wtm_pkg;

    localparam int SAMPLE_DEPTH = 16;
    localparam int SLOT_W       = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);
    localparam int MIN_SAMPLES  = 2;

    localparam int TIME_W  = 32;
    localparam int BYTES_W = 32;
    localparam int WIN_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int RATE_W  = 44;

    // byte sum over a full ring, then the dividend after the Q8 shift
    localparam int SUM_W  = BYTES_W + SLOT_W;
    localparam int DIV_W  = SUM_W + FRAC_W;
    localparam int WIDE_W = (DIV_W > RATE_W) ? DIV_W : RATE_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(5);
    localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_PUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

endpackage
`default_nettype wire

>>> rtl/wtm_if.sv
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface wtm_in_if import wtm_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                action;
    logic [TIME_W-1:0]   now_time;
    logic [BYTES_W-1:0]  sample_bytes;

    modport source (output valid, action, now_time, sample_bytes, input ready);
    modport sink   (input valid, action, now_time, sample_bytes, output ready);
endinterface

interface wtm_out_if import wtm_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [RATE_W-1:0]   rate_q8;
    logic                rate_valid;

    modport source (output valid, rate_q8, rate_valid, input ready);
    modport sink   (input valid, rate_q8, rate_valid, output ready);
endinterface
`default_nettype wire

>>> rtl/windowed_throughput_meter.sv
// Top level of the windowed throughput meter: sample ring, query sequencer, output register.
`default_nettype none
// Sliding-window rate meter. Add words (action 0) store {now_time, sample_bytes}
// in a ring of SAMPLE_DEPTH slots, overwriting the oldest, and give no result.
// Query words (action 1) give one result word: the byte sum over stored samples
// stamped at or after now_time - window_seconds (clamped at zero), divided by the
// span from the earlier of now_time and the earliest such stamp to the latest
// such stamp, as unsigned Q8 truncated. Fewer than two stored or qualifying
// samples, or zero span, give rate_valid 0 and rate_q8 0. A query walks the ring
// through the sample RAM's single read port, an S_RD and an S_ACC state per
// stored sample, then runs the restoring divider at one bit per cycle over DIV_W
// (44) bits, and hands the result word to the output register before the next
// word is taken. A query over fewer than two stored samples skips the ring walk;
// one that finds no valid span skips the divider. The input is not ready during
// a query; a finished result sits in the output register, so the next word can be
// taken while it waits. window_seconds resets to 5 and is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module windowed_throughput_meter import wtm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [WIN_W-1:0]  i_cfg_wdata,
    wtm_in_if.sink                 i_in,
    wtm_out_if.source              o_out
);

    t_state              r_state, n_state;
    logic [WIN_W-1:0]    r_window;
    logic [SLOT_W-1:0]   r_wr_slot, n_wr_slot;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [TIME_W-1:0]   r_start, n_start;
    logic [TIME_W-1:0]   r_earliest, n_earliest;
    logic [TIME_W-1:0]   r_latest, n_latest;
    logic [SUM_W-1:0]    r_total, n_total;
    logic [1:0]          r_hits, n_hits;
    logic                r_out_vld, n_out_vld;
    logic [RATE_W-1:0]   r_rate, n_rate;
    logic                r_rvalid, n_rvalid;
    logic [RATE_W-1:0]   r_res_rate, n_res_rate;
    logic                r_res_vld, n_res_vld;

    logic                in_acc;
    logic                ram_we;
    logic [TIME_W+BYTES_W-1:0] ram_rdata;
    logic [TIME_W-1:0]   rd_time;
    logic [BYTES_W-1:0]  rd_bytes;
    logic                hit;
    logic                last;
    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [WIDE_W-1:0]   quo_wide;

    assign in_acc   = i_in.valid && i_in.ready;
    assign ram_we   = in_acc && (i_in.action == ACT_ADD);
    assign rd_time  = ram_rdata[TIME_W+BYTES_W-1:BYTES_W];
    assign rd_bytes = ram_rdata[BYTES_W-1:0];
    assign hit      = (rd_time >= r_start);
    assign last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_fill);
    assign quo_wide = WIDE_W'(div_quo);

    // ring storage: {timestamp, bytes} per slot
    wtm_ram #(
        .WIDTH (TIME_W + BYTES_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_slot),
        .i_wdata ({i_in.now_time, i_in.sample_bytes}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    wtm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_total, FRAC_W'(0)}),
        .i_divisor  (r_latest - r_earliest),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_vld;
    assign o_out.rate_q8    = r_rate;
    assign o_out.rate_valid = r_rvalid;

    always_comb begin
        n_state    = r_state;
        n_wr_slot  = r_wr_slot;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_start    = r_start;
        n_earliest = r_earliest;
        n_latest   = r_latest;
        n_total    = r_total;
        n_hits     = r_hits;
        n_res_rate = r_res_rate;
        n_res_vld  = r_res_vld;
        n_out_vld  = r_out_vld;
        n_rate     = r_rate;
        n_rvalid   = r_rvalid;
        div_start  = 1'b0;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == ACT_ADD) begin
                        n_wr_slot = (r_wr_slot == SLOT_W'(SAMPLE_DEPTH - 1))
                                  ? '0 : r_wr_slot + SLOT_W'(1);
                        if (r_fill != CNT_W'(SAMPLE_DEPTH)) begin
                            n_fill = r_fill + CNT_W'(1);
                        end
                    end else begin
                        n_start    = (i_in.now_time >= TIME_W'(r_window))
                                   ? i_in.now_time - TIME_W'(r_window) : '0;
                        n_earliest = i_in.now_time;
                        n_latest   = '0;
                        n_total    = '0;
                        n_hits     = '0;
                        n_idx      = '0;
                        n_res_rate = '0;
                        n_res_vld  = 1'b0;
                        n_state    = (r_fill < CNT_W'(MIN_SAMPLES)) ? S_PUT : S_RD;
                    end
                end
            end
            S_RD: begin
                // read address is r_idx; data lands next cycle
                n_state = S_ACC;
            end
            S_ACC: begin
                if (hit) begin
                    n_total = r_total + SUM_W'(rd_bytes);
                    if (rd_time < r_earliest) n_earliest = rd_time;
                    if (rd_time > r_latest)   n_latest   = rd_time;
                    if (r_hits != 2'd2)       n_hits     = r_hits + 2'd1;
                end
                if (last) begin
                    n_state = S_CHK;
                end else begin
                    n_idx   = r_idx + SLOT_W'(1);
                    n_state = S_RD;
                end
            end
            S_CHK: begin
                if (r_hits != 2'd2 || r_latest <= r_earliest) begin
                    n_state = S_PUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res_rate = (quo_wide > WIDE_W'(RATE_MAX))
                               ? RATE_MAX : RATE_W'(quo_wide);
                    n_res_vld  = 1'b1;
                    n_state    = S_PUT;
                end
            end
            S_PUT, S_WAIT: begin
                // hand over once the output register is free
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_rate    = r_res_rate;
                    n_rvalid  = r_res_vld;
                    n_state   = S_IDLE;
                end else begin
                    n_state   = S_WAIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_window  <= WINDOW_RESET;
            r_wr_slot <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
            r_hits    <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_wr_slot <= n_wr_slot;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
            r_hits    <= n_hits;
            r_idx     <= n_idx;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
        r_start    <= n_start;
        r_earliest <= n_earliest;
        r_latest   <= n_latest;
        r_total    <= n_total;
        r_res_rate <= n_res_rate;
        r_res_vld  <= n_res_vld;
        r_rate     <= n_rate;
        r_rvalid   <= n_rvalid;
    end

    // an invalid result always carries a zero rate
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.rate_valid) |-> (o_out.rate_q8 == '0))
        else $error("invalid result with nonzero rate");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(SAMPLE_DEPTH))
        else $error("fill count past ring depth");

    a_fill_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_fill != CNT_W'(SAMPLE_DEPTH)) |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("add word did not grow the fill count");

    a_div_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_latest > r_earliest && r_hits == 2'd2))
        else $error("divider started without a valid span");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (CNT_W'(r_idx) < r_fill))
        else $error("scan read past stored samples");

endmodule
`default_nettype wire

>>> rtl/wtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/wtm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module wtm_div import wtm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIV_W-1:0]   i_dividend,
    input  wire logic [TIME_W-1:0]  i_divisor,
    output      logic               o_done,
    output      logic [DIV_W-1:0]   o_quotient
);

    logic [TIME_W:0]   r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [TIME_W-1:0] r_dvs, n_dvs;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [TIME_W:0]   trial;
    logic              fits;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem[TIME_W-1:0], r_quo[DIV_W-1]};
        fits   = (trial >= {1'b0, r_dvs});
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = STEP_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder stays below the divisor, so trial fits in 33 bits
            n_rem  = fits ? (trial - {1'b0, r_dvs}) : trial;
            n_quo  = {r_quo[DIV_W-2:0], fits};
            n_cnt  = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the windowed throughput meter.
module tb;
    import wtm_pkg::*;

    // One input word: an add (stamp + byte count) or a query (current time).
    typedef struct packed {
        logic               action;
        logic [TIME_W-1:0]  now_time;
        logic [BYTES_W-1:0] sample_bytes;
    } t_meter_word;

    // One result word, as the meter reports it for a query.
    typedef struct packed {
        logic [RATE_W-1:0] rate_q8;
        logic              rate_valid;
    } t_rate_word;

    localparam int CLK_HALF     = 6;
    localparam int SETTLE_WAIT  = 120;      // longer than one full-ring query
    localparam int LONG_STALL   = 400;      // receiver hold-off, in cycles
    localparam int CYCLE_LIMIT  = 1000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [WIN_W-1:0]  i_cfg_wdata = '0;

    wtm_in_if  in_if ();
    wtm_out_if out_if ();

    windowed_throughput_meter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Every block input known from time zero.
    initial begin
        in_if.valid        = 1'b0;
        in_if.action       = ACT_ADD;
        in_if.now_time     = '0;
        in_if.sample_bytes = '0;
        out_if.ready       = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the sample ring and the window.
    // ------------------------------------------------------------------
    logic [BYTES_W-1:0] ring_bytes [SAMPLE_DEPTH];
    logic [TIME_W-1:0]  ring_stamp [SAMPLE_DEPTH];
    int                 ring_head = 0;
    int                 ring_fill = 0;
    logic [WIN_W-1:0]   window_cfg = WINDOW_RESET;

    t_meter_word word_q [$];     // words waiting for the driver
    t_rate_word  rate_q [$];     // expected rates, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;

    logic long_stall_req  = 1'b0;
    logic long_stall_done = 1'b0;
    int   stall_left      = 0;

    // Work out what the meter does with one accepted word. Adds update the
    // ring; queries push the rate they should report.
    task automatic meter_apply(input t_meter_word w);
        logic [TIME_W-1:0] win_lo;
        logic [TIME_W-1:0] earliest;
        logic [TIME_W-1:0] latest;
        logic [TIME_W-1:0] span;
        logic [63:0]       total;
        logic [63:0]       quot;
        int                hits;
        t_rate_word        res;

        if (w.action == ACT_ADD) begin
            ring_bytes[ring_head] = w.sample_bytes;
            ring_stamp[ring_head] = w.now_time;
            ring_head = (ring_head + 1) % SAMPLE_DEPTH;
            if (ring_fill < SAMPLE_DEPTH)
                ring_fill++;
            return;
        end

        res = '0;
        if (ring_fill >= MIN_SAMPLES) begin
            // window start clamps at zero when the window reaches past time 0
            win_lo   = (w.now_time >= TIME_W'(window_cfg)) ?
                       w.now_time - TIME_W'(window_cfg) : '0;
            earliest = w.now_time;
            latest   = '0;
            total    = '0;
            hits     = 0;
            for (int i = 0; i < ring_fill; i++) begin
                if (ring_stamp[i] >= win_lo) begin
                    total += 64'(ring_bytes[i]);
                    if (ring_stamp[i] < earliest)
                        earliest = ring_stamp[i];
                    // stamps in the future may push latest past now_time
                    if (ring_stamp[i] > latest)
                        latest = ring_stamp[i];
                    hits++;
                end
            end
            if (hits >= MIN_SAMPLES && latest > earliest) begin
                span = latest - earliest;
                quot = (total << FRAC_W) / 64'(span);
                res.rate_q8    = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
                res.rate_valid = 1'b1;
            end
        end
        rate_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next queued word, idling at random. A word is
    // predicted at the edge where the meter takes it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_meter_word nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                meter_apply('{in_if.action, in_if.now_time, in_if.sample_bytes});
            if (!in_if.valid || in_if.ready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = word_q.pop_front();
                    in_if.action       <= nxt.action;
                    in_if.now_time     <= nxt.now_time;
                    in_if.sample_bytes <= nxt.sample_bytes;
                    in_if.valid        <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result word against the oldest expectation and
    // drives ready, including one long hold-off that backs the meter up.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rate_word exp_w;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (rate_q.size() == 0) begin
                    $error("result word with no expected rate pending");
                    err_cnt++;
                end else begin
                    exp_w = rate_q.pop_front();
                    if (out_if.rate_q8 !== exp_w.rate_q8) begin
                        $error("rate_q8 mismatch: expected %0h, actual %0h",
                               exp_w.rate_q8, out_if.rate_q8);
                        err_cnt++;
                    end
                    if (out_if.rate_valid !== exp_w.rate_valid) begin
                        $error("rate_valid mismatch: expected %0b, actual %0b",
                               exp_w.rate_valid, out_if.rate_valid);
                        err_cnt++;
                    end
                end
            end
            if (long_stall_req && !long_stall_done) begin
                long_stall_done <= 1'b1;
                stall_left      <= LONG_STALL;
                out_if.ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Hard stop for a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_word(input logic act, input logic [TIME_W-1:0] t,
                             input logic [BYTES_W-1:0] b);
        word_q.push_back('{act, t, b});
    endtask

    // Wait until every queued word is taken and every rate has come back,
    // then let any trailing work finish. Sampled at negedge, where all
    // edge updates have settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (word_q.size() != 0 || in_if.valid || rate_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Only called with the meter drained.
    task automatic write_window(input logic [WIN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_cfg = v;
    endtask

    // Random traffic: mostly a steady stream of samples on an advancing
    // clock with queries near the present, plus some unrelated noise words.
    task automatic gen_traffic(input int n);
        logic [TIME_W-1:0]  sec;
        logic [TIME_W-1:0]  qt;
        logic [BYTES_W-1:0] b;
        int                 r;

        sec = $urandom_range(0, 100000);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 3) begin
                sec = $urandom;                 // far jump, wraps near 2^32
            end else if (r < 5) begin
                sec = $urandom_range(0, 12);    // window start clamps at zero
            end
            if (r >= 5 && r < 12) begin
                push_word(1'($urandom_range(1)), $urandom, $urandom);
            end else if ($urandom_range(99) < 30) begin
                case ($urandom_range(3))
                    0:       qt = sec - $urandom_range(0, 4);   // stamps in the future
                    1:       qt = sec + $urandom_range(0, 3 * window_cfg + 3);
                    default: qt = sec + $urandom_range(0, 8);
                endcase
                push_word(ACT_QUERY, qt, $urandom);
            end else begin
                sec = sec + $urandom_range(0, 3);   // zero steps give equal stamps
                case ($urandom_range(4))
                    0:       b = $urandom;
                    1:       b = $urandom_range(1) ? '1 : '0;
                    default: b = $urandom_range(0, 5000);
                endcase
                push_word(ACT_ADD, sec, b);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 67;

        // Directed, reset window of 5 s: empty and single-sample queries,
        // zero span, byte extremes, a future stamp, no hits, clamped start.
        push_word(ACT_QUERY, 32'd0, 32'd0);
        push_word(ACT_ADD,   32'd100, 32'd0);
        push_word(ACT_QUERY, 32'd100, 32'd0);
        push_word(ACT_ADD,   32'd100, '1);
        push_word(ACT_QUERY, 32'd100, 32'd0);
        push_word(ACT_ADD,   32'd101, '1);
        push_word(ACT_QUERY, 32'd101, '1);
        push_word(ACT_ADD,   32'd200, 32'd1234);
        push_word(ACT_QUERY, 32'd102, 32'd0);
        push_word(ACT_QUERY, 32'd300, 32'd0);
        push_word(ACT_QUERY, 32'd3, 32'd0);
        push_word(ACT_QUERY, '1, 32'd0);
        push_word(ACT_ADD,   '1, '1);
        push_word(ACT_ADD,   32'hFFFF_FFFE, 32'd1);
        push_word(ACT_QUERY, '1, 32'd0);
        wait_drained();

        // zero-length window: start sits at now_time
        write_window('0);
        push_word(ACT_QUERY, 32'd200, 32'd0);
        push_word(ACT_QUERY, 32'd101, 32'd0);
        wait_drained();

        write_window('1);
        push_word(ACT_QUERY, 32'd65535, 32'd0);
        push_word(ACT_QUERY, 32'd70000, 32'd0);
        wait_drained();

        // Random part, one window setting per chunk.
        write_window(WIN_W'(3));
        gen_traffic(205);
        wait_drained();

        write_window(WIN_W'(1));
        gen_traffic(205);
        wait_drained();

        send_idle_pct = 67;
        recv_idle_pct = 28;
        write_window(WIN_W'(12));
        gen_traffic(205);
        wait_drained();

        write_window(WIN_W'($urandom_range(1, 65535)));
        gen_traffic(205);
        wait_drained();

        // No idling; the long receiver hold-off backs up the meter here.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_window(WIN_W'(8));
        gen_traffic(205);
        long_stall_req <= 1'b1;
        wait_drained();

        write_window('1);
        gen_traffic(205);
        wait_drained();

        if (err_cnt == 0 && rate_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
